/* src/p2a_pkg.sv */
// Shared types, constants and codes for the pixel to ASCII mapper.
// No dependencies; every other file uses it through scoped names.
package p2a_pkg;

   localparam int PALETTE_SIZE = 16;
   localparam int MAX_COLUMNS  = 4096;
   localparam int MAX_ROWS     = 4096;
   localparam int QUEUE_DEPTH  = 4;

   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int DIM_W       = 13;
   localparam int LEN_W       = 5;
   localparam int PIX_W       = 8;
   localparam int CHAR_W      = 8;
   localparam int PALETTE_W   = 2 * CSR_DATA_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PALETTE_LOW    = 3'd0,
      CSR_PALETTE_HIGH   = 3'd1,
      CSR_PALETTE_LENGTH = 3'd2,
      CSR_HIGHLIGHT      = 3'd3,
      CSR_IMAGE_WIDTH    = 3'd4,
      CSR_IMAGE_HEIGHT   = 3'd5
   } csr_index_type;

   localparam int LUMA_R = 299;
   localparam int LUMA_G = 587;
   localparam int LUMA_B = 114;
   localparam int SUM_W  = 18;   // 1000 * 255 fits

   // floor(x / 1000) = (x * 268436) >> 28 for every x below 2^18
   localparam int DIV1000_MUL   = 268436;
   localparam int DIV1000_W     = 19;
   localparam int DIV1000_SHIFT = 28;

   localparam int HIGHLIGHT_ADD = 32;
   localparam int GRAY_MAX      = 255;
   localparam logic [CHAR_W-1:0] CHAR_EMPTY = 8'd63;

   localparam int IDX_W  = $clog2(PALETTE_SIZE);
   localparam int PROD_W = PIX_W + IDX_W;

   // floor(p / 255) = (p * 4113) >> 20 for every p below 2^12
   localparam int DIV255_MUL   = 4113;
   localparam int DIV255_W     = 13;
   localparam int DIV255_SHIFT = 20;

   typedef struct packed {
      logic [PIX_W-1:0] gray;
      logic             eol;
      logic             eof;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } geom_cfg_type;

   typedef struct packed {
      logic [PALETTE_W-1:0] palette;
      logic [LEN_W-1:0]     length;
      logic                 highlight;
   } map_cfg_type;

endpackage

/* src/p2a_front.sv */
// Front end: accepts pixels, computes luma in two stages, tracks line/frame position.
// Depends on p2a_pkg; feeds p2a_queue.
module p2a_front #(
   parameter int MAX_COLUMNS = p2a_pkg::MAX_COLUMNS,
   parameter int MAX_ROWS    = p2a_pkg::MAX_ROWS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_push,
   output logic                       in_full,
   input  logic [p2a_pkg::PIX_W-1:0]  in_blue,
   input  logic [p2a_pkg::PIX_W-1:0]  in_green,
   input  logic [p2a_pkg::PIX_W-1:0]  in_red,
   input  p2a_pkg::geom_cfg_type      geom,
   input  p2a_pkg::q_status_type      q_status,
   output logic                       q_push,
   output p2a_pkg::q_entry_type       q_data
);

   localparam int CW   = $clog2(MAX_COLUMNS);
   localparam int RW   = $clog2(MAX_ROWS);
   localparam int CE   = (CW + 1 > p2a_pkg::DIM_W) ? CW + 1 : p2a_pkg::DIM_W;
   localparam int RE   = (RW + 1 > p2a_pkg::DIM_W) ? RW + 1 : p2a_pkg::DIM_W;
   localparam int SW   = p2a_pkg::SUM_W;
   localparam int MW   = p2a_pkg::SUM_W + p2a_pkg::DIV1000_W;

   logic          s1_valid_ff, s1_valid_in;
   logic          s2_valid_ff, s2_valid_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic          s1_eol_ff, s1_eof_ff, s2_eol_ff, s2_eof_ff;
   logic [p2a_pkg::PIX_W-1:0] gray_ff, gray_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic          ready1, ready2, accept;
   logic [CE-1:0] w_ext;
   logic [RE-1:0] h_ext;
   logic [CW-1:0] last_col;
   logic [RW-1:0] last_row;
   logic          eol, eof;
   logic [MW-1:0] div_prod;

   assign ready2  = !s2_valid_ff || !q_status.full;
   assign ready1  = !s1_valid_ff || ready2;
   assign in_full = !ready1;
   assign accept  = in_push && ready1;
   assign q_push  = s2_valid_ff && !q_status.full;

   // zero dimensions act as one, oversize ones saturate
   always_comb begin
      w_ext = CE'(geom.width);
      h_ext = RE'(geom.height);
      if (w_ext == '0) begin
         last_col = '0;
      end else if (w_ext > CE'(MAX_COLUMNS)) begin
         last_col = CW'(MAX_COLUMNS - 1);
      end else begin
         last_col = CW'(w_ext - CE'(1));
      end
      if (h_ext == '0) begin
         last_row = '0;
      end else if (h_ext > RE'(MAX_ROWS)) begin
         last_row = RW'(MAX_ROWS - 1);
      end else begin
         last_row = RW'(h_ext - RE'(1));
      end
   end

   always_comb begin
      eol    = col_ff >= last_col;
      eof    = eol && (row_ff >= last_row);
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         col_in = eol ? '0 : col_ff + CW'(1);
         if (eol) begin
            row_in = eof ? '0 : row_ff + RW'(1);
         end
      end
   end

   assign sum_in = SW'(in_red)   * SW'(p2a_pkg::LUMA_R)
                 + SW'(in_green) * SW'(p2a_pkg::LUMA_G)
                 + SW'(in_blue)  * SW'(p2a_pkg::LUMA_B);

   assign div_prod = MW'(sum_ff) * MW'(p2a_pkg::DIV1000_MUL);
   assign gray_in  = div_prod[p2a_pkg::DIV1000_SHIFT +: p2a_pkg::PIX_W];

   assign s1_valid_in = ready1 ? accept : s1_valid_ff;
   assign s2_valid_in = ready2 ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         sum_ff    <= sum_in;
         s1_eol_ff <= eol;
         s1_eof_ff <= eof;
      end
      if (ready2) begin
         gray_ff   <= gray_in;
         s2_eol_ff <= s1_eol_ff;
         s2_eof_ff <= s1_eof_ff;
      end
   end

   assign q_data.gray = gray_ff;
   assign q_data.eol  = s2_eol_ff;
   assign q_data.eof  = s2_eof_ff;

endmodule

/* src/p2a_queue.sv */
// Short FIFO between the luma front end and the palette back end.
// Depends on p2a_pkg for the entry type and depth.
module p2a_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  p2a_pkg::q_entry_type  wr_data,
   input  logic                  rd_en,
   output p2a_pkg::q_entry_type  rd_data,
   output p2a_pkg::q_status_type status
);

   localparam int DEPTH = p2a_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);

   p2a_pkg::q_entry_type entry_ff [DEPTH];
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [NW-1:0] count_ff, count_in;

   assign status.full  = count_ff == NW'(DEPTH);
   assign status.empty = count_ff == '0;
   assign rd_data      = entry_ff[head_ff];

   always_comb begin
      head_in  = rd_en ? PW'((head_ff + PW'(1)) % DEPTH) : head_ff;
      tail_in  = wr_en ? PW'((tail_ff + PW'(1)) % DEPTH) : tail_ff;
      count_in = count_ff + NW'(wr_en) - NW'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[tail_ff] <= wr_data;
      end
   end

endmodule

/* src/p2a_back.sv */
// Back end: highlight, palette index scaling and character lookup, with output register.
// Depends on p2a_pkg; drains p2a_queue.
module p2a_back (
   input  logic                        clock,
   input  logic                        reset,
   input  p2a_pkg::map_cfg_type        cfg,
   input  p2a_pkg::q_status_type       q_status,
   input  p2a_pkg::q_entry_type        q_data,
   output logic                        q_pop,
   output logic                        out_empty,
   input  logic                        out_pop,
   output logic [p2a_pkg::CHAR_W-1:0]  out_character,
   output logic                        out_end_of_line,
   output logic                        out_end_of_frame
);

   localparam int GW = p2a_pkg::PIX_W;
   localparam int IW = p2a_pkg::IDX_W;
   localparam int PW = p2a_pkg::PROD_W;
   localparam int DW = p2a_pkg::PROD_W + p2a_pkg::DIV255_W;
   localparam int LW = p2a_pkg::LEN_W;

   logic          b1_valid_ff, b1_valid_in;
   logic          b2_valid_ff, b2_valid_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic          none_ff, none_in;
   logic          b1_eol_ff, b1_eof_ff;
   logic [p2a_pkg::CHAR_W-1:0] char_ff, char_in;
   logic          b2_eol_ff, b2_eof_ff;

   logic          ready1, ready2;
   logic [GW:0]   gray_sum;
   logic [GW-1:0] gray_hl;
   logic [LW-1:0] len_sat;
   logic [IW-1:0] len_m1;
   logic [DW-1:0] div_prod;
   logic [IW-1:0] idx;

   assign ready2    = !b2_valid_ff || out_pop;
   assign ready1    = !b1_valid_ff || ready2;
   assign q_pop     = ready1 && !q_status.empty;
   assign out_empty = !b2_valid_ff;

   always_comb begin
      gray_sum = (GW + 1)'(q_data.gray);
      if (cfg.highlight) begin
         gray_sum = gray_sum + (GW + 1)'(p2a_pkg::HIGHLIGHT_ADD);
      end
      gray_hl = (gray_sum > (GW + 1)'(p2a_pkg::GRAY_MAX)) ? GW'(p2a_pkg::GRAY_MAX)
                                                          : gray_sum[GW-1:0];
      len_sat = (cfg.length > LW'(p2a_pkg::PALETTE_SIZE)) ? LW'(p2a_pkg::PALETTE_SIZE)
                                                           : cfg.length;
      none_in = len_sat == '0;
      len_m1  = IW'(len_sat - LW'(1));
      prod_in = PW'(gray_hl) * PW'(len_m1);
   end

   // divide by 255 via reciprocal, then pick the palette byte
   always_comb begin
      div_prod = DW'(prod_ff) * DW'(p2a_pkg::DIV255_MUL);
      idx      = div_prod[p2a_pkg::DIV255_SHIFT +: IW];
      char_in  = none_ff ? p2a_pkg::CHAR_EMPTY
                         : cfg.palette[{idx, 3'd0} +: p2a_pkg::CHAR_W];
   end

   assign b1_valid_in = ready1 ? !q_status.empty : b1_valid_ff;
   assign b2_valid_in = ready2 ? b1_valid_ff : b2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= b1_valid_in;
         b2_valid_ff <= b2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         prod_ff   <= prod_in;
         none_ff   <= none_in;
         b1_eol_ff <= q_data.eol;
         b1_eof_ff <= q_data.eof;
      end
      if (ready2) begin
         char_ff   <= char_in;
         b2_eol_ff <= b1_eol_ff;
         b2_eof_ff <= b1_eof_ff;
      end
   end

   assign out_character    = char_ff;
   assign out_end_of_line  = b2_eol_ff;
   assign out_end_of_frame = b2_eof_ff;

endmodule

/* src/pixel_to_ascii_mapper_core.sv */
// Pixel to ASCII mapper top level: register file, front end, queue, back end.
// Throughput: one request per cycle unless pop holds results back; set by the two-stage
// luma path and the two-stage palette path, decoupled by a 4-entry queue.
// Reset (synchronous): pipelines and queue empty, counters zero, registers at defaults.
// Depends on p2a_pkg, p2a_front, p2a_queue, p2a_back.
module pixel_to_ascii_mapper_core #(
   parameter int MAX_COLUMNS = p2a_pkg::MAX_COLUMNS,
   parameter int MAX_ROWS    = p2a_pkg::MAX_ROWS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic [p2a_pkg::PIX_W-1:0]        req_blue,
   input  logic [p2a_pkg::PIX_W-1:0]        req_green,
   input  logic [p2a_pkg::PIX_W-1:0]        req_red,
   output logic                             empty,
   input  logic                             pop,
   output logic [p2a_pkg::CHAR_W-1:0]       rsp_character,
   output logic                             rsp_end_of_line,
   output logic                             rsp_end_of_frame,
   input  logic                             csr_write_enable,
   input  logic [p2a_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [p2a_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic [p2a_pkg::CSR_DATA_W-1:0] pal_low_ff, pal_high_ff;
   logic [p2a_pkg::LEN_W-1:0]      pal_len_ff;
   logic                           highlight_ff;
   logic [p2a_pkg::DIM_W-1:0]      width_ff, height_ff;

   p2a_pkg::geom_cfg_type geom;
   p2a_pkg::map_cfg_type  map_cfg;
   p2a_pkg::q_status_type q_status;
   p2a_pkg::q_entry_type  q_wr_data, q_rd_data;
   logic                  q_push, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_low_ff   <= '0;
         pal_high_ff  <= '0;
         pal_len_ff   <= '0;
         highlight_ff <= 1'b0;
         width_ff     <= p2a_pkg::DIM_W'(1);
         height_ff    <= p2a_pkg::DIM_W'(1);
      end else if (csr_write_enable) begin
         unique case (p2a_pkg::csr_index_type'(csr_index))
            p2a_pkg::CSR_PALETTE_LOW:    pal_low_ff   <= csr_data;
            p2a_pkg::CSR_PALETTE_HIGH:   pal_high_ff  <= csr_data;
            p2a_pkg::CSR_PALETTE_LENGTH: pal_len_ff   <= csr_data[p2a_pkg::LEN_W-1:0];
            p2a_pkg::CSR_HIGHLIGHT:      highlight_ff <= csr_data[0];
            p2a_pkg::CSR_IMAGE_WIDTH:    width_ff     <= csr_data[p2a_pkg::DIM_W-1:0];
            p2a_pkg::CSR_IMAGE_HEIGHT:   height_ff    <= csr_data[p2a_pkg::DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign geom.width        = width_ff;
   assign geom.height       = height_ff;
   assign map_cfg.palette   = {pal_high_ff, pal_low_ff};
   assign map_cfg.length    = pal_len_ff;
   assign map_cfg.highlight = highlight_ff;

   p2a_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_push  (push),
      .in_full  (full),
      .in_blue  (req_blue),
      .in_green (req_green),
      .in_red   (req_red),
      .geom     (geom),
      .q_status (q_status),
      .q_push   (q_push),
      .q_data   (q_wr_data)
   );

   p2a_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_data),
      .rd_en   (q_pop),
      .rd_data (q_rd_data),
      .status  (q_status)
   );

   p2a_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (map_cfg),
      .q_status         (q_status),
      .q_data           (q_rd_data),
      .q_pop            (q_pop),
      .out_empty        (empty),
      .out_pop          (pop),
      .out_character    (rsp_character),
      .out_end_of_line  (rsp_end_of_line),
      .out_end_of_frame (rsp_end_of_frame)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("queue written while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("queue read while empty");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result pending right after reset");

   a_eof_has_eol: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_end_of_frame) |-> rsp_end_of_line)
      else $error("end of frame without end of line");

endmodule
